// ----- rtl/stmc_pkg.sv -----
// ----------------------------------------------------------------------------
// stmc_pkg
// Shared types and codes for the minimum Steiner tree cost engine.
// ----------------------------------------------------------------------------
package stmc_pkg;

   // transaction function codes
   localparam logic [1:0] FUNC_TERMINAL = 2'd0;
   localparam logic [1:0] FUNC_EDGE     = 2'd1;
   localparam logic [1:0] FUNC_COMPUTE  = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_CONN  = 2'd1;
   localparam logic [1:0] STATUS_OK_DROP   = 2'd2;

   // configuration register indexes
   localparam logic CSR_NODE_COUNT     = 1'b0;
   localparam logic CSR_TERMINAL_COUNT = 1'b1;

   localparam int NODE_FIELD_W  = 8;
   localparam int WEIGHT_W      = 20;
   localparam int COST_W        = 40;
   localparam int EDGE_W        = 2 * NODE_FIELD_W + WEIGHT_W;
   localparam int NODE_CFG_W    = 9;
   localparam int TERM_CFG_W    = 3;

   typedef struct packed {
      logic [1:0]              func;
      logic [2:0]              terminal_index;
      logic [NODE_FIELD_W-1:0] node_a;
      logic [NODE_FIELD_W-1:0] node_b;
      logic [WEIGHT_W-1:0]     edge_weight;
   } req_type;

   typedef struct packed {
      logic [COST_W-1:0] tree_cost;
      logic [1:0]        status;
   } rsp_type;

   // engine result towards the top level
   typedef struct packed {
      logic              done;
      logic              reach;
      logic [COST_W-1:0] cost;
   } eng_rsp_type;

endpackage

// ----- rtl/steiner_tree_min_cost.sv -----
// Load transactions are accepted back to back while the engine is idle.
// A compute transaction clears the table, merges every subset split, and per
// subset runs Dijkstra rounds that each scan the nodes and walk every stored
// edge, all bound by the single distance memory port;
// the result is registered after the final minimum scan.
// Synchronous active-high reset clears edge count and terminals, sets both config registers to one.
// ----------------------------------------------------------------------------
// steiner_tree_min_cost
// Top level: configuration, terminal table, edge loading, result register.
// ----------------------------------------------------------------------------
module steiner_tree_min_cost #(
   parameter int MAX_NODES     = 256,
   parameter int MAX_TERMINALS = 5,
   parameter int MAX_EDGES     = 1024,
   parameter int DIST_WIDTH    = 40
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  stmc_pkg::req_type                    req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output stmc_pkg::rsp_type                    rsp_payload,
   input  logic                                 csr_we,
   input  logic                                 csr_index,
   input  logic [stmc_pkg::NODE_CFG_W-1:0]      csr_wdata
);

   localparam int NCW = $clog2(MAX_NODES+1);
   localparam int KW  = NCW > stmc_pkg::NODE_CFG_W ? NCW : stmc_pkg::NODE_CFG_W;
   localparam int TCW = $clog2(MAX_TERMINALS+1);
   localparam int ECW = $clog2(MAX_EDGES+1);
   localparam int EW  = MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1;

   logic [stmc_pkg::NODE_CFG_W-1:0] node_cfg_ff, node_cfg_in;
   logic [stmc_pkg::TERM_CFG_W-1:0] term_cfg_ff, term_cfg_in;
   logic [MAX_TERMINALS-1:0][stmc_pkg::NODE_FIELD_W-1:0] term_ff, term_in;
   logic [ECW-1:0]                  ecount_ff, ecount_in;
   logic                            eovf_ff, eovf_in;
   logic                            start_ff, start_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   stmc_pkg::rsp_type               rsp_ff, rsp_in;

   logic                            accept;
   logic                            edge_we;
   logic [NCW-1:0]                  node_num;
   logic [TCW-1:0]                  term_num;
   logic                            busy;
   stmc_pkg::eng_rsp_type           eng;

   // input stalls while the engine runs; a compute also stalls while a result still waits
   assign req_stall = busy | start_ff |
                      (rsp_valid_ff & (req_payload.func == stmc_pkg::FUNC_COMPUTE));
   assign accept    = req_valid & ~req_stall;
   assign edge_we   = accept & (req_payload.func == stmc_pkg::FUNC_EDGE) &
                      (ecount_ff < ECW'(MAX_EDGES));

   // clamp registers to the supported range
   always_comb begin
      if (node_cfg_ff == '0) begin
         node_num = NCW'(1);
      end else if (KW'(node_cfg_ff) > KW'(MAX_NODES)) begin
         node_num = NCW'(MAX_NODES);
      end else begin
         node_num = NCW'(node_cfg_ff);
      end
      if (term_cfg_ff == '0) begin
         term_num = TCW'(1);
      end else if (4'(term_cfg_ff) > 4'(MAX_TERMINALS)) begin
         term_num = TCW'(MAX_TERMINALS);
      end else begin
         term_num = TCW'(term_cfg_ff);
      end
   end

   // configuration, loads and result register
   always_comb begin
      node_cfg_in  = node_cfg_ff;
      term_cfg_in  = term_cfg_ff;
      term_in      = term_ff;
      ecount_in    = ecount_ff;
      eovf_in      = eovf_ff;
      start_in     = 1'b0;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_in       = rsp_ff;
      if (csr_we) begin
         unique case (csr_index)
            stmc_pkg::CSR_NODE_COUNT:     node_cfg_in = csr_wdata;
            stmc_pkg::CSR_TERMINAL_COUNT:
               term_cfg_in = csr_wdata[stmc_pkg::TERM_CFG_W-1:0];
            default: ;
         endcase
      end
      if (accept) begin
         case (req_payload.func)
            stmc_pkg::FUNC_TERMINAL: begin
               for (int k = 0; k < MAX_TERMINALS; k++) begin
                  if (4'(req_payload.terminal_index) == 4'(k)) begin
                     term_in[k] = req_payload.node_a;
                  end
               end
            end
            stmc_pkg::FUNC_EDGE: begin
               if (ecount_ff < ECW'(MAX_EDGES)) begin
                  ecount_in = ecount_ff + ECW'(1);
               end else begin
                  eovf_in = 1'b1;
               end
            end
            stmc_pkg::FUNC_COMPUTE: start_in = 1'b1;
            default: ;
         endcase
      end
      if (eng.done) begin
         rsp_valid_in = 1'b1;
         if (eng.reach) begin
            rsp_in.tree_cost = eng.cost;
            rsp_in.status    = eovf_ff ? stmc_pkg::STATUS_OK_DROP : stmc_pkg::STATUS_OK;
         end else begin
            rsp_in.tree_cost = '0;
            rsp_in.status    = stmc_pkg::STATUS_NOT_CONN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_cfg_ff  <= stmc_pkg::NODE_CFG_W'(1);
         term_cfg_ff  <= stmc_pkg::TERM_CFG_W'(1);
         term_ff      <= '0;
         ecount_ff    <= '0;
         eovf_ff      <= 1'b0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         node_cfg_ff  <= node_cfg_in;
         term_cfg_ff  <= term_cfg_in;
         term_ff      <= term_in;
         ecount_ff    <= ecount_in;
         eovf_ff      <= eovf_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   stmc_engine #(
      .MAX_NODES     (MAX_NODES),
      .MAX_TERMINALS (MAX_TERMINALS),
      .MAX_EDGES     (MAX_EDGES),
      .DIST_WIDTH    (DIST_WIDTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (start_ff),
      .node_num   (node_num),
      .term_num   (term_num),
      .terminals  (term_ff),
      .edge_num   (ecount_ff),
      .edge_we    (edge_we),
      .edge_waddr (ecount_ff[EW-1:0]),
      .edge_wdata ({req_payload.node_a, req_payload.node_b, req_payload.edge_weight}),
      .busy       (busy),
      .result     (eng)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ----- rtl/stmc_ram.sv -----
// ----------------------------------------------------------------------------
// stmc_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module stmc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                         wdata,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/stmc_engine.sv -----
// ----------------------------------------------------------------------------
// stmc_engine
// Sequencer over the subset distance memory and the edge memory: clears the
// table, seeds terminals, merges splits, relaxes in Dijkstra order, takes min.
// ----------------------------------------------------------------------------
module stmc_engine #(
   parameter int MAX_NODES     = 256,
   parameter int MAX_TERMINALS = 5,
   parameter int MAX_EDGES     = 1024,
   parameter int DIST_WIDTH    = 40
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             start,
   input  logic [$clog2(MAX_NODES+1)-1:0]                   node_num,
   input  logic [$clog2(MAX_TERMINALS+1)-1:0]               term_num,
   input  logic [MAX_TERMINALS-1:0][stmc_pkg::NODE_FIELD_W-1:0] terminals,
   input  logic [$clog2(MAX_EDGES+1)-1:0]                   edge_num,
   input  logic                                             edge_we,
   input  logic [(MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1)-1:0] edge_waddr,
   input  logic [stmc_pkg::EDGE_W-1:0]                      edge_wdata,
   output logic                                             busy,
   output stmc_pkg::eng_rsp_type                            result
);

   localparam int NW   = $clog2(MAX_NODES);
   localparam int NCW  = $clog2(MAX_NODES+1);
   localparam int TW   = MAX_TERMINALS;
   localparam int TCW  = $clog2(MAX_TERMINALS+1);
   localparam int ECW  = $clog2(MAX_EDGES+1);
   localparam int EW   = MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1;
   localparam int AW   = NW + TW;
   localparam int DW   = DIST_WIDTH;
   localparam int CW   = NCW > stmc_pkg::NODE_FIELD_W ? NCW : stmc_pkg::NODE_FIELD_W;
   localparam int FW   = stmc_pkg::NODE_FIELD_W;
   localparam logic [DW-1:0] INF = '1;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_CLR   = 4'd1;
   localparam logic [3:0] ST_TERM  = 4'd2;
   localparam logic [3:0] ST_MINIT = 4'd3;
   localparam logic [3:0] ST_MP    = 4'd4;
   localparam logic [3:0] ST_MR    = 4'd5;
   localparam logic [3:0] ST_MS    = 4'd6;
   localparam logic [3:0] ST_MCMP  = 4'd7;
   localparam logic [3:0] ST_RINIT = 4'd8;
   localparam logic [3:0] ST_SCAN  = 4'd9;
   localparam logic [3:0] ST_ERD   = 4'd10;
   localparam logic [3:0] ST_ECHK  = 4'd11;
   localparam logic [3:0] ST_EUPD  = 4'd12;
   localparam logic [3:0] ST_FSCAN = 4'd13;
   localparam logic [3:0] ST_DONE  = 4'd14;

   function automatic logic [DW-1:0] sat_add(input logic [DW-1:0] x,
                                             input logic [DW-1:0] y);
      logic [DW:0] sum;
      begin
         sum = {1'b0, x} + {1'b0, y};
         if (x == INF || y == INF || sum >= {1'b0, INF}) begin
            sat_add = INF;
         end else begin
            sat_add = sum[DW-1:0];
         end
      end
   endfunction

   function automatic logic node_ok(input logic [FW-1:0] a, input logic [NCW-1:0] n);
      begin
         node_ok = CW'(a) < CW'(n);
      end
   endfunction

   logic [3:0]           state_ff, state_in;
   logic [TW-1:0]        s_ff, s_in;
   logic [TW-1:0]        part_ff, part_in;
   logic [NCW-1:0]       v_ff, v_in;
   logic [AW-1:0]        clr_ff, clr_in;
   logic [TCW-1:0]       i_ff, i_in;
   logic [NCW-1:0]       scan_ff, scan_in;
   logic                 rdv_ff, rdv_in;
   logic [NW-1:0]        rdn_ff, rdn_in;
   logic [DW-1:0]        bd_ff, bd_in;
   logic [NW-1:0]        best_ff, best_in;
   logic                 found_ff, found_in;
   logic [MAX_NODES-1:0] seen_ff, seen_in;
   logic [ECW-1:0]       e_ff, e_in;
   logic [DW-1:0]        pd_ff, pd_in;
   logic [DW-1:0]        sum_ff, sum_in;
   logic [NW-1:0]        other_ff, other_in;

   logic [TW-1:0]        full;
   logic [TW-1:0]        rest;
   logic [TW-1:0]        part_dec;
   logic [NCW-1:0]       n_last;
   logic [FW-1:0]        term_sel;
   logic                 d_we;
   logic [AW-1:0]        d_addr;
   logic [DW-1:0]        d_wdata;
   logic [DW-1:0]        d_rdata;
   logic [EW-1:0]        e_addr;
   logic [stmc_pkg::EDGE_W-1:0] e_rdata;
   logic [FW-1:0]        ea;
   logic [FW-1:0]        eb;
   logic [stmc_pkg::WEIGHT_W-1:0] ew;
   logic [63:0]          cost_wide;

   stmc_ram #(.WIDTH(DW), .DEPTH(MAX_NODES << MAX_TERMINALS)) u_dist_ram (
      .clock (clock),
      .we    (d_we),
      .addr  (d_addr),
      .wdata (d_wdata),
      .rdata (d_rdata)
   );

   stmc_ram #(.WIDTH(stmc_pkg::EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock (clock),
      .we    (edge_we),
      .addr  (e_addr),
      .wdata (edge_wdata),
      .rdata (e_rdata)
   );

   // full terminal set and helpers
   always_comb begin
      full = '0;
      for (int k = 0; k < TW; k++) begin
         full[k] = (TCW'(k) < term_num);
      end
      term_sel = '0;
      for (int k = 0; k < MAX_TERMINALS; k++) begin
         if (i_ff == TCW'(k)) begin
            term_sel = terminals[k];
         end
      end
   end

   assign rest     = s_ff ^ part_ff;
   assign part_dec = (part_ff - TW'(1)) & s_ff;
   assign n_last   = node_num - NCW'(1);
   assign ea       = e_rdata[stmc_pkg::EDGE_W-1 -: FW];
   assign eb       = e_rdata[stmc_pkg::WEIGHT_W +: FW];
   assign ew       = e_rdata[stmc_pkg::WEIGHT_W-1:0];
   assign e_addr   = (state_ff == ST_IDLE) ? edge_waddr : e_ff[EW-1:0];

   // sequencer
   always_comb begin
      state_in = state_ff;
      s_in     = s_ff;
      part_in  = part_ff;
      v_in     = v_ff;
      clr_in   = clr_ff;
      i_in     = i_ff;
      scan_in  = scan_ff;
      rdv_in   = 1'b0;
      rdn_in   = rdn_ff;
      bd_in    = bd_ff;
      best_in  = best_ff;
      found_in = found_ff;
      seen_in  = seen_ff;
      e_in     = e_ff;
      pd_in    = pd_ff;
      sum_in   = sum_ff;
      other_in = other_ff;
      d_we     = 1'b0;
      d_addr   = '0;
      d_wdata  = INF;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               clr_in   = '0;
               state_in = ST_CLR;
            end
         end
         // fill every entry of the nodes in use with infinity
         ST_CLR: begin
            d_we   = 1'b1;
            d_addr = clr_ff;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == {n_last[NW-1:0], {TW{1'b1}}}) begin
               i_in     = '0;
               state_in = ST_TERM;
            end
         end
         // seed singleton subsets
         ST_TERM: begin
            if (i_ff < term_num) begin
               if (node_ok(term_sel, node_num)) begin
                  d_we    = 1'b1;
                  d_addr  = {NW'(term_sel), TW'(1) << i_ff};
                  d_wdata = '0;
               end
               i_in = i_ff + TCW'(1);
            end else begin
               s_in     = TW'(1);
               state_in = ST_MINIT;
            end
         end
         ST_MINIT: begin
            part_in = (s_ff - TW'(1)) & s_ff;
            v_in    = '0;
            if (((s_ff - TW'(1)) & s_ff) == '0) begin
               state_in = ST_RINIT;
            end else begin
               state_in = ST_MP;
            end
         end
         // merge: read part, rest and own entry, write back the smaller
         ST_MP: begin
            d_addr   = {v_ff[NW-1:0], part_ff};
            state_in = ST_MR;
         end
         ST_MR: begin
            pd_in    = d_rdata;
            d_addr   = {v_ff[NW-1:0], rest};
            state_in = ST_MS;
         end
         ST_MS: begin
            sum_in   = sat_add(pd_ff, d_rdata);
            d_addr   = {v_ff[NW-1:0], s_ff};
            state_in = ST_MCMP;
         end
         ST_MCMP: begin
            d_addr  = {v_ff[NW-1:0], s_ff};
            d_wdata = sum_ff;
            d_we    = sum_ff < d_rdata;
            if (v_ff < n_last) begin
               v_in     = v_ff + NCW'(1);
               state_in = ST_MP;
            end else if (part_dec == '0) begin
               state_in = ST_RINIT;
            end else begin
               part_in  = part_dec;
               v_in     = '0;
               state_in = ST_MP;
            end
         end
         ST_RINIT: begin
            seen_in  = '0;
            scan_in  = '0;
            bd_in    = INF;
            found_in = 1'b0;
            state_in = ST_SCAN;
         end
         // search the closest unvisited node, one read per cycle
         ST_SCAN: begin
            d_addr = {scan_ff[NW-1:0], s_ff};
            if (scan_ff < node_num) begin
               scan_in = scan_ff + NCW'(1);
               rdv_in  = 1'b1;
               rdn_in  = scan_ff[NW-1:0];
            end
            if (rdv_ff) begin
               if (!seen_ff[rdn_ff] && d_rdata < bd_ff) begin
                  bd_in    = d_rdata;
                  best_in  = rdn_ff;
                  found_in = 1'b1;
               end
            end else if (scan_ff >= node_num) begin
               if (found_ff) begin
                  seen_in[best_ff] = 1'b1;
                  e_in             = '0;
                  state_in         = ST_ERD;
               end else if (s_ff == full) begin
                  scan_in  = '0;
                  bd_in    = INF;
                  state_in = ST_FSCAN;
               end else begin
                  s_in     = s_ff + TW'(1);
                  state_in = ST_MINIT;
               end
            end
         end
         // walk the edge list from the visited node
         ST_ERD: begin
            if (e_ff < edge_num) begin
               state_in = ST_ECHK;
            end else begin
               scan_in  = '0;
               bd_in    = INF;
               found_in = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_ECHK: begin
            e_in     = e_ff + ECW'(1);
            state_in = ST_ERD;
            if (node_ok(ea, node_num) && node_ok(eb, node_num)) begin
               if (CW'(ea) == CW'(best_ff) || CW'(eb) == CW'(best_ff)) begin
                  other_in = (CW'(ea) == CW'(best_ff)) ? NW'(eb) : NW'(ea);
                  sum_in   = sat_add(bd_ff, DW'(ew));
                  d_addr   = {((CW'(ea) == CW'(best_ff)) ? NW'(eb) : NW'(ea)), s_ff};
                  state_in = ST_EUPD;
               end
            end
         end
         ST_EUPD: begin
            d_addr   = {other_ff, s_ff};
            d_wdata  = sum_ff;
            d_we     = sum_ff < d_rdata;
            state_in = ST_ERD;
         end
         // minimum over the full set
         ST_FSCAN: begin
            d_addr = {scan_ff[NW-1:0], full};
            if (scan_ff < node_num) begin
               scan_in = scan_ff + NCW'(1);
               rdv_in  = 1'b1;
            end
            if (rdv_ff) begin
               if (d_rdata < bd_ff) begin
                  bd_in = d_rdata;
               end
            end else if (scan_ff >= node_num) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rdv_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         rdv_ff   <= rdv_in;
      end
      s_ff     <= s_in;
      part_ff  <= part_in;
      v_ff     <= v_in;
      clr_ff   <= clr_in;
      i_ff     <= i_in;
      scan_ff  <= scan_in;
      rdn_ff   <= rdn_in;
      bd_ff    <= bd_in;
      best_ff  <= best_in;
      found_ff <= found_in;
      seen_ff  <= seen_in;
      e_ff     <= e_in;
      pd_ff    <= pd_in;
      sum_ff   <= sum_in;
      other_ff <= other_in;
   end

   // result
   assign cost_wide    = 64'(bd_ff);
   assign busy         = (state_ff != ST_IDLE);
   assign result.done  = (state_ff == ST_DONE);
   assign result.reach = (bd_ff != INF);
   assign result.cost  = cost_wide[stmc_pkg::COST_W-1:0];

endmodule

// ----- rtl/stmc_checker.sv -----
// ----------------------------------------------------------------------------
// stmc_checker
// Port-level assertions for the Steiner tree cost block.
// ----------------------------------------------------------------------------
module stmc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input stmc_pkg::req_type req_payload,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input stmc_pkg::rsp_type rsp_payload
);

   // stalled result transaction holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // no result right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // unconnected result reports zero cost
   a_not_conn: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == stmc_pkg::STATUS_NOT_CONN
         |-> rsp_payload.tree_cost == '0)
      else $error("unconnected result with nonzero cost");

   // accepted compute transaction blocks further input
   a_compute_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_payload.func == stmc_pkg::FUNC_COMPUTE |=> req_stall)
      else $error("input accepted during compute");

   // no result without an earlier compute
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_payload.func != stmc_pkg::FUNC_COMPUTE && !rsp_valid
         |=> !rsp_valid)
      else $error("result without compute");

endmodule

bind steiner_tree_min_cost stmc_checker u_stmc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the minimum Steiner tree cost engine against a behavioral predictor.
// Terminal and edge loads, computes and unused codes are driven through a
// valid/stall channel with random gaps on both sides; registers are written directly.
// ----------------------------------------------------------------------------
module tb;

   localparam int         NODES_MAX = 256;
   localparam int         TERMS_MAX = 5;
   localparam int         EDGES_MAX = 1024;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam logic [63:0] DIST_INF = 64'hFF_FFFF_FFFF;
   localparam int         CYCLE_LIMIT = 40_000_000;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   stmc_pkg::req_type               req_payload;
   logic                            rsp_valid;
   logic                            rsp_stall;
   stmc_pkg::rsp_type               rsp_payload;
   logic                            csr_we;
   logic                            csr_index;
   logic [stmc_pkg::NODE_CFG_W-1:0] csr_wdata;

   steiner_tree_min_cost u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // graph state mirrored by the predictor
   logic [7:0]  term_node [TERMS_MAX];
   logic [7:0]  edge_a [EDGES_MAX];
   logic [7:0]  edge_b [EDGES_MAX];
   logic [19:0] edge_w [EDGES_MAX];
   int          edge_total;
   logic        edges_dropped;
   logic [8:0]  cfg_nodes;
   logic [2:0]  cfg_terms;
   logic [63:0] cost_tab [NODES_MAX][32];
   logic        settled [NODES_MAX];

   stmc_pkg::req_type pending_q [$];
   stmc_pkg::rsp_type cost_q [$];
   int      send_idle_pct;
   int      recv_idle_pct;
   int      fail_count;
   int      cycle_count;
   logic    req_fire;

   function automatic logic [63:0] sat_sum(logic [63:0] x, logic [63:0] y);
      if (x >= DIST_INF || y >= DIST_INF || y >= DIST_INF - x) return DIST_INF;
      return x + y;
   endfunction

   // full Steiner dp: subset merges then Dijkstra per subset
   function automatic stmc_pkg::rsp_type steiner_cost();
      int                n, t, full, s, part, v, r, e, pick, other;
      logic [63:0]       bd, c, best;
      stmc_pkg::rsp_type res;
      n = (cfg_nodes == 0) ? 1 : (cfg_nodes > NODES_MAX ? NODES_MAX : cfg_nodes);
      t = (cfg_terms == 0) ? 1 : (cfg_terms > TERMS_MAX ? TERMS_MAX : cfg_terms);
      full = (1 << t) - 1;
      for (v = 0; v < n; v++)
         for (s = 0; s < 32; s++) cost_tab[v][s] = DIST_INF;
      for (int i = 0; i < t; i++)
         if (term_node[i] < n) cost_tab[term_node[i]][1 << i] = 0;
      for (s = 1; s <= full; s++) begin
         for (part = (s - 1) & s; part > 0; part = (part - 1) & s)
            for (v = 0; v < n; v++) begin
               c = sat_sum(cost_tab[v][part], cost_tab[v][s ^ part]);
               if (c < cost_tab[v][s]) cost_tab[v][s] = c;
            end
         for (v = 0; v < n; v++) settled[v] = 1'b0;
         for (r = 0; r < n; r++) begin
            pick = n;
            bd = DIST_INF;
            for (v = 0; v < n; v++)
               if (!settled[v] && cost_tab[v][s] < bd) begin
                  bd = cost_tab[v][s];
                  pick = v;
               end
            if (pick >= n) break;
            settled[pick] = 1'b1;
            for (e = 0; e < edge_total; e++) begin
               if (edge_a[e] >= n || edge_b[e] >= n) continue;
               if (edge_a[e] == pick) other = edge_b[e];
               else if (edge_b[e] == pick) other = edge_a[e];
               else continue;
               c = sat_sum(bd, {44'd0, edge_w[e]});
               if (c < cost_tab[other][s]) cost_tab[other][s] = c;
            end
         end
      end
      best = DIST_INF;
      for (v = 0; v < n; v++)
         if (cost_tab[v][full] < best) best = cost_tab[v][full];
      if (best >= DIST_INF) begin
         res.tree_cost = '0;
         res.status = stmc_pkg::STATUS_NOT_CONN;
      end else begin
         res.tree_cost = best[stmc_pkg::COST_W-1:0];
         res.status = edges_dropped ? stmc_pkg::STATUS_OK_DROP : stmc_pkg::STATUS_OK;
      end
      return res;
   endfunction

   // apply one accepted transaction to the mirrored state
   task automatic absorb_item(stmc_pkg::req_type it);
      case (it.func)
         stmc_pkg::FUNC_TERMINAL: begin
            if (it.terminal_index < TERMS_MAX) term_node[it.terminal_index] = it.node_a;
         end
         stmc_pkg::FUNC_EDGE: begin
            if (edge_total < EDGES_MAX) begin
               edge_a[edge_total] = it.node_a;
               edge_b[edge_total] = it.node_b;
               edge_w[edge_total] = it.edge_weight;
               edge_total++;
            end else begin
               edges_dropped = 1'b1;
            end
         end
         stmc_pkg::FUNC_COMPUTE: cost_q.insert(cost_q.size(), steiner_cost());
         default: ;
      endcase
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         if (!req_valid || req_fire) begin
            if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_payload <= pending_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      stmc_pkg::rsp_type want;
      req_fire <= req_valid && !req_stall && !reset;
      if (!reset) begin
         cycle_count <= cycle_count + 1;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
         if (req_valid && !req_stall) absorb_item(req_payload);
         if (rsp_valid && !rsp_stall) begin
            if (cost_q.size() == 0) begin
               $display("%0t: unexpected result cost=%0d status=%0d", $time,
                        rsp_payload.tree_cost, rsp_payload.status);
               fail_count++;
            end else begin
               want = cost_q.pop_front();
               if (rsp_payload.tree_cost !== want.tree_cost) begin
                  $display("%0t: tree_cost expected %0d actual %0d", $time,
                           want.tree_cost, rsp_payload.tree_cost);
                  fail_count++;
               end
               if (rsp_payload.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time,
                           want.status, rsp_payload.status);
                  fail_count++;
               end
            end
         end
      end
   end

   task automatic queue_item(logic [1:0] func, logic [2:0] slot, logic [7:0] a,
                             logic [7:0] b, logic [19:0] w);
      stmc_pkg::req_type it;
      it.func = func;
      it.terminal_index = slot;
      it.node_a = a;
      it.node_b = b;
      it.edge_weight = w;
      pending_q.insert(pending_q.size(), it);
   endtask

   // wait for the engine to go idle, then write both registers
   task automatic set_graph_size(logic [8:0] nodes, logic [2:0] terms);
      wait (pending_q.size() == 0 && !req_valid && cost_q.size() == 0);
      repeat (20) @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= stmc_pkg::CSR_NODE_COUNT;
      csr_wdata <= nodes;
      @(negedge clock);
      cfg_nodes = nodes;
      csr_index <= stmc_pkg::CSR_TERMINAL_COUNT;
      csr_wdata <= {6'd0, terms};
      @(negedge clock);
      cfg_terms = terms;
      csr_we <= 1'b0;
   endtask

   // stimulus
   initial begin
      int n_use, n_edges, n_terms;
      logic [8:0]  nodes;
      logic [7:0]  na, nb;
      logic [19:0] w;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_stall = 1'b0;
      req_fire = 1'b0;
      csr_we = 1'b0;
      csr_index = stmc_pkg::CSR_NODE_COUNT;
      csr_wdata = '0;
      send_idle_pct = 15;
      recv_idle_pct = 59;
      fail_count = 0;
      cycle_count = 0;
      edge_total = 0;
      edges_dropped = 1'b0;
      cfg_nodes = 9'd1;
      cfg_terms = 3'd1;
      for (int i = 0; i < TERMS_MAX; i++) term_node[i] = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset settings, then a small graph with zero and max weights
      queue_item(stmc_pkg::FUNC_COMPUTE, 3'd0, 8'd0, 8'd0, 20'd0);
      set_graph_size(9'd5, 3'd3);
      queue_item(stmc_pkg::FUNC_TERMINAL, 3'd0, 8'd0, 8'd0, 20'd0);
      queue_item(stmc_pkg::FUNC_TERMINAL, 3'd1, 8'd4, 8'd0, 20'd0);
      queue_item(stmc_pkg::FUNC_TERMINAL, 3'd2, 8'd2, 8'd0, 20'd0);
      queue_item(stmc_pkg::FUNC_TERMINAL, 3'd7, 8'd3, 8'd0, 20'd0);
      queue_item(FUNC_UNUSED, 3'd7, 8'hFF, 8'hFF, 20'hFFFFF);
      queue_item(stmc_pkg::FUNC_EDGE, 3'd0, 8'd0, 8'd1, 20'd0);
      queue_item(stmc_pkg::FUNC_EDGE, 3'd0, 8'd1, 8'd4, 20'hFFFFF);
      queue_item(stmc_pkg::FUNC_EDGE, 3'd0, 8'd2, 8'd1, 20'd5);
      queue_item(stmc_pkg::FUNC_EDGE, 3'd0, 8'd3, 8'd255, 20'd7);
      queue_item(stmc_pkg::FUNC_COMPUTE, 3'd0, 8'd0, 8'd0, 20'd0);
      queue_item(stmc_pkg::FUNC_TERMINAL, 3'd2, 8'd200, 8'd0, 20'd0);
      queue_item(stmc_pkg::FUNC_COMPUTE, 3'd0, 8'd0, 8'd0, 20'd0);
      set_graph_size(9'd0, 3'd0);
      queue_item(stmc_pkg::FUNC_COMPUTE, 3'd0, 8'd0, 8'd0, 20'd0);
      set_graph_size(9'd511, 3'd7);
      queue_item(stmc_pkg::FUNC_COMPUTE, 3'd0, 8'd0, 8'd0, 20'd0);

      // random batches, each closed by a compute
      for (int batch = 0; batch < 45; batch++) begin
         if (batch == 15) begin
            send_idle_pct = 59;
            recv_idle_pct = 15;
         end else if (batch == 30) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case ($urandom_range(19))
            0: nodes = 9'd0;
            1: nodes = 9'd256;
            2: nodes = 9'd511;
            3: nodes = 9'd255;
            default: nodes = 9'($urandom_range(1, 10));
         endcase
         set_graph_size(nodes, 3'($urandom_range(0, 7)));
         n_use = (nodes == 0) ? 1 : (nodes > NODES_MAX ? NODES_MAX : nodes);
         n_terms = $urandom_range(2, 6);
         n_edges = $urandom_range(0, 2);
         for (int k = 0; k < n_terms; k++) begin
            na = ($urandom_range(9) < 8) ? 8'($urandom_range(0, n_use - 1))
                                         : 8'($urandom_range(0, 255));
            queue_item(stmc_pkg::FUNC_TERMINAL, 3'($urandom_range(0, 7)), na,
                       8'($urandom), 20'($urandom));
            if ($urandom_range(9) == 0)
               queue_item(FUNC_UNUSED, 3'($urandom), 8'($urandom), 8'($urandom),
                          20'($urandom));
         end
         for (int k = 0; k < n_edges; k++) begin
            if ($urandom_range(4) == 0) begin
               na = 8'($urandom);
               nb = 8'($urandom);
            end else begin
               na = 8'($urandom_range(0, n_use - 1));
               nb = 8'($urandom_range(0, n_use - 1));
            end
            case ($urandom_range(3))
               0: w = 20'($urandom);
               1: w = ($urandom_range(1)) ? 20'hFFFFF : 20'd0;
               default: w = 20'($urandom_range(0, 100));
            endcase
            queue_item(stmc_pkg::FUNC_EDGE, 3'($urandom), na, nb, w);
         end
         queue_item(stmc_pkg::FUNC_COMPUTE, 3'($urandom), 8'($urandom), 8'($urandom),
                    20'($urandom));
      end

      // fill the edge store past capacity, then small computes
      set_graph_size(9'd1, 3'd1);
      queue_item(stmc_pkg::FUNC_TERMINAL, 3'd0, 8'd0, 8'd0, 20'd0);
      for (int k = edge_total; k < EDGES_MAX + 3; k++)
         queue_item(stmc_pkg::FUNC_EDGE, 3'd0, 8'($urandom_range(100, 255)),
                    8'($urandom), 20'($urandom));
      queue_item(stmc_pkg::FUNC_COMPUTE, 3'd0, 8'd0, 8'd0, 20'd0);
      queue_item(stmc_pkg::FUNC_TERMINAL, 3'd0, 8'd9, 8'd0, 20'd0);
      queue_item(stmc_pkg::FUNC_COMPUTE, 3'd0, 8'd0, 8'd0, 20'd0);

      wait (pending_q.size() == 0 && !req_valid && cost_q.size() == 0);
      repeat (50) @(negedge clock);
      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
